### rtl/modbus_rtu_frame_delimiter_crc_assert.svh
// ---------------------------------------------------------------------------
// Modbus RTU delimiter assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MODBUS_RTU_FRAME_DELIMITER_CRC_ASSERT_SVH
`define MODBUS_RTU_FRAME_DELIMITER_CRC_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define MBRTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MBRTU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBRTU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MBRTU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/mbrtu_pkg.sv
// ---------------------------------------------------------------------------
// Modbus RTU delimiter package
// Beat types, function codes, status codes and the CRC-16 byte update.
// ---------------------------------------------------------------------------
package mbrtu_pkg;

	// input beat
	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} mbrtu_in_t;

	// result beat
	typedef struct packed {
		logic [8:0] byte_position;
		logic       frame_end;
		logic [2:0] status;
		logic [8:0] frame_length;
		logic [7:0] function_code;
	} mbrtu_out_t;

	// status codes
	localparam logic [2:0] ST_IN_FRAME   = 3'd0;
	localparam logic [2:0] ST_FRAME_OK   = 3'd1;
	localparam logic [2:0] ST_CRC_ERR    = 3'd2;
	localparam logic [2:0] ST_UNKNOWN_FC = 3'd3;
	localparam logic [2:0] ST_DISCARD    = 3'd4;

	// function codes
	localparam logic [7:0] FC_READ_COILS      = 8'h01;
	localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
	localparam logic [7:0] FC_WRITE_REG       = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

	// direction register values
	localparam logic DIR_REQUEST  = 1'b0;
	localparam logic DIR_RESPONSE = 1'b1;

	// frame lengths and byte positions
	localparam logic [8:0] LEN_EXCEPTION = 9'd5;
	localparam logic [8:0] LEN_FIXED     = 9'd8;
	localparam logic [8:0] LEN_RSP_BASE  = 9'd5;
	localparam logic [8:0] LEN_REQ_BASE  = 9'd9;
	localparam logic [8:0] POS_FUNC      = 9'd1;
	localparam logic [8:0] POS_RSP_COUNT = 9'd2;
	localparam logic [8:0] POS_REQ_COUNT = 9'd6;

	// CRC-16/MODBUS
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// one byte through the reflected CRC, eight shift steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/modbus_rtu_frame_delimiter_crc.sv
// A result beat is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; the byte-wide CRC
// update and the length decode sit between the frame state registers and
// the result register; in_ready is high while it is empty or draining.
// Reset (arst_n low, asynchronous): frame state cleared, CRC to 0xFFFF,
// direction to request parsing, no result pending.
// ---------------------------------------------------------------------------
// Modbus RTU frame delimiter with CRC-16 check
// Works out frame boundaries from the function code and checks the CRC.
// ---------------------------------------------------------------------------
`include "modbus_rtu_frame_delimiter_crc_assert.svh"

module modbus_rtu_frame_delimiter_crc
	import mbrtu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  mbrtu_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output mbrtu_out_t out_data
);

	// configuration and frame state
	logic        direction_q;
	logic [8:0]  byte_count_q;
	logic [8:0]  expected_length_q;
	logic        length_known_q;
	logic [7:0]  func_q;
	logic [15:0] running_crc_q;
	logic [15:0] payload_crc_q;
	logic [7:0]  crc_low_q;
	logic        discarding_q;

	// result register
	logic        out_valid_q;
	mbrtu_out_t  out_data_q;

	// state as seen by this beat (after optional restart) and next state
	logic [8:0]  cnt_e, len_e, cnt_n, len_n;
	logic        known_e, disc_e, known_n, disc_n;
	logic [7:0]  func_e, func_n, clow_e, clow_n, b;
	logic [15:0] crc_e, pcrc_e, crc_n, pcrc_n;
	logic [9:0]  pos_p1, pos_p2, len_w;
	logic        fc_bad;
	logic        in_fire;
	mbrtu_out_t  res;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign b         = in_data.data_byte;

	// restart drops the partial frame before this byte is looked at
	always_comb begin
		if (in_data.restart) begin
			cnt_e   = '0;
			len_e   = '0;
			known_e = 1'b0;
			func_e  = '0;
			crc_e   = CRC_INIT;
			pcrc_e  = '0;
			clow_e  = '0;
			disc_e  = 1'b0;
		end else begin
			cnt_e   = byte_count_q;
			len_e   = expected_length_q;
			known_e = length_known_q;
			func_e  = func_q;
			crc_e   = running_crc_q;
			pcrc_e  = payload_crc_q;
			clow_e  = crc_low_q;
			disc_e  = discarding_q;
		end
	end

	// frame parse and CRC for one byte
	always_comb begin
		cnt_n   = cnt_e;
		len_n   = len_e;
		known_n = known_e;
		func_n  = func_e;
		crc_n   = crc_e;
		pcrc_n  = pcrc_e;
		clow_n  = clow_e;
		disc_n  = disc_e;
		fc_bad  = 1'b0;
		pos_p1  = {1'b0, cnt_e} + 10'd1;
		pos_p2  = {1'b0, cnt_e} + 10'd2;
		len_w   = '0;

		res.byte_position = cnt_e;
		res.frame_end     = 1'b0;
		res.status        = ST_IN_FRAME;
		res.frame_length  = '0;
		res.function_code = func_e;

		if (disc_e) begin
			res.byte_position = '0;
			res.status        = ST_DISCARD;
		end else begin
			// length decode: function code byte or byte count byte
			if (cnt_e == POS_FUNC) begin
				func_n = b;
				if (b[7]) begin
					len_n   = LEN_EXCEPTION;
					known_n = 1'b1;
				end else if (direction_q == DIR_REQUEST) begin
					case (b) inside
						[FC_READ_COILS:FC_WRITE_REG]: begin
							len_n   = LEN_FIXED;
							known_n = 1'b1;
						end
						FC_WRITE_COILS, FC_WRITE_REGS: begin
						end
						default: begin
							fc_bad = 1'b1;
						end
					endcase
				end else begin
					case (b) inside
						[FC_READ_COILS:FC_READ_INPUT_REGS]: begin
						end
						FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
							len_n   = LEN_FIXED;
							known_n = 1'b1;
						end
						default: begin
							fc_bad = 1'b1;
						end
					endcase
				end
			end else if (!known_e) begin
				if (direction_q == DIR_RESPONSE && cnt_e == POS_RSP_COUNT
						&& func_e >= FC_READ_COILS && func_e <= FC_READ_INPUT_REGS) begin
					len_n   = LEN_RSP_BASE + {1'b0, b};
					known_n = 1'b1;
				end else if (direction_q == DIR_REQUEST && cnt_e == POS_REQ_COUNT
						&& (func_e == FC_WRITE_COILS || func_e == FC_WRITE_REGS)) begin
					len_n   = LEN_REQ_BASE + {1'b0, b};
					known_n = 1'b1;
				end
			end

			len_w = {1'b0, len_n};

			if (fc_bad) begin
				// unknown code: report it and drop bytes until restart
				disc_n             = 1'b1;
				len_n              = '0;
				known_n            = 1'b0;
				res.status         = ST_UNKNOWN_FC;
				res.function_code  = b;
			end else begin
				res.frame_length  = known_n ? len_n : 9'd0;
				res.function_code = func_n;
				if (known_n && pos_p1 == len_w) begin
					// last byte: CRC high byte, compare and clear the frame
					res.frame_end = 1'b1;
					res.status    = ({b, clow_e} == pcrc_e) ? ST_FRAME_OK : ST_CRC_ERR;
					cnt_n   = '0;
					len_n   = '0;
					known_n = 1'b0;
					func_n  = '0;
					crc_n   = CRC_INIT;
					pcrc_n  = '0;
					clow_n  = '0;
					disc_n  = 1'b0;
				end else begin
					if (known_n && pos_p2 == len_w) begin
						pcrc_n = crc_e;
						clow_n = b;
					end else begin
						crc_n = crc16_byte(crc_e, b);
					end
					cnt_n = pos_p1[8:0];
				end
			end
		end
	end

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_REQUEST;
		end else if (cfg_valid && cfg_ready) begin
			direction_q <= cfg_data;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			expected_length_q <= '0;
			length_known_q    <= 1'b0;
			func_q            <= '0;
			running_crc_q     <= CRC_INIT;
			payload_crc_q     <= '0;
			crc_low_q         <= '0;
			discarding_q      <= 1'b0;
		end else if (in_fire) begin
			byte_count_q      <= cnt_n;
			expected_length_q <= len_n;
			length_known_q    <= known_n;
			func_q            <= func_n;
			running_crc_q     <= crc_n;
			payload_crc_q     <= pcrc_n;
			crc_low_q         <= clow_n;
			discarding_q      <= disc_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

	// checks
	`MBRTU_ASSERT_IMP(a_end_status, clk, arst_n, out_valid_q && out_data_q.frame_end, out_data_q.status == ST_FRAME_OK || out_data_q.status == ST_CRC_ERR, "frame end without a CRC verdict")
	`MBRTU_ASSERT_NXT(a_end_clears, clk, arst_n, in_fire && res.frame_end, byte_count_q == 9'd0 && !length_known_q, "frame state not cleared after last byte")
	`MBRTU_ASSERT_IMP(a_disc_no_len, clk, arst_n, discarding_q, !length_known_q && expected_length_q == 9'd0, "length held while discarding")
	`MBRTU_ASSERT_IMP(a_count_in_len, clk, arst_n, length_known_q, byte_count_q < expected_length_q, "byte count past frame length")

endmodule
